// ===== hw/rtl/tfc_pkg.sv =====
// Shared types and constants for the TCP flow table classifier.
`default_nettype none
package tfc_pkg;

  localparam int TABLE_ENTRIES_DEF    = 64;
  localparam int PACKETS_PER_FLOW_DEF = 64;
  localparam int IDX_W                = 6;
  localparam int SLOT_W               = 6;

  typedef enum logic [1:0] {
    OUT_ADDED      = 2'd0,
    OUT_NEW        = 2'd1,
    OUT_CONN_FULL  = 2'd2,
    OUT_TABLE_FULL = 2'd3
  } outcome_t;

  typedef struct packed {
    logic [31:0] src_address;
    logic [31:0] dst_address;
    logic [15:0] src_port_num;
    logic [15:0] dst_port_num;
    logic        end_of_batch;
  } pkt_t;

  typedef struct packed {
    logic [IDX_W-1:0]  flow_index;
    logic [SLOT_W-1:0] packet_slot;
    outcome_t          outcome;
    logic              reverse_direction;
    logic              batch_end;
  } res_t;

  // request walking down the cell row; res starts as the table-full answer
  typedef struct packed {
    logic        valid;
    logic        done;
    logic [31:0] src;
    logic [31:0] dst;
    logic [15:0] sport;
    logic [15:0] dport;
    res_t        res;
  } token_t;

endpackage
`default_nettype wire

// ===== hw/rtl/tfc_cell.sv =====
// One flow table entry: holds a connection and resolves a passing request.
`default_nettype none
module tfc_cell #(
  parameter int INDEX            = 0,
  parameter int PACKETS_PER_FLOW = tfc_pkg::PACKETS_PER_FLOW_DEF
) (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            advance,
  input  wire tfc_pkg::token_t tok_in,
  output tfc_pkg::token_t      tok_out
);

  localparam int          CNT_W = $clog2(PACKETS_PER_FLOW + 1);
  localparam logic [31:0] IDX   = 32'(INDEX);
  localparam logic [31:0] LIMIT = 32'(PACKETS_PER_FLOW);

  // open bits of the row form a thermometer code of the connection count
  logic             open;
  logic [31:0]      key_src;
  logic [31:0]      key_dst;
  logic [15:0]      key_sport;
  logic [15:0]      key_dport;
  logic [CNT_W-1:0] count;

  tfc_pkg::token_t  tok_next;
  logic             fwd;
  logic             rev;
  logic             act;
  logic [31:0]      count_ext;
  logic             do_alloc;
  logic             do_incr;

  assign count_ext = 32'(count);
  assign act = tok_in.valid && !tok_in.done;
  assign fwd = key_src == tok_in.src && key_dst == tok_in.dst &&
               key_sport == tok_in.sport && key_dport == tok_in.dport;
  assign rev = key_src == tok_in.dst && key_dst == tok_in.src &&
               key_sport == tok_in.dport && key_dport == tok_in.sport;

  always_comb begin
    tok_next = tok_in;
    do_alloc = 1'b0;
    do_incr  = 1'b0;
    if (act) begin
      if (!open) begin
        // first free entry: open the connection here
        do_alloc                            = 1'b1;
        tok_next.done                       = 1'b1;
        tok_next.res.flow_index             = IDX[tfc_pkg::IDX_W-1:0];
        tok_next.res.packet_slot            = '0;
        tok_next.res.outcome                = tfc_pkg::OUT_NEW;
        tok_next.res.reverse_direction      = 1'b0;
      end else if (fwd || rev) begin
        tok_next.done                       = 1'b1;
        tok_next.res.flow_index             = IDX[tfc_pkg::IDX_W-1:0];
        tok_next.res.reverse_direction      = !fwd;
        if (count_ext >= LIMIT) begin
          tok_next.res.packet_slot          = '0;
          tok_next.res.outcome              = tfc_pkg::OUT_CONN_FULL;
        end else begin
          do_incr                           = 1'b1;
          tok_next.res.packet_slot          = count_ext[tfc_pkg::SLOT_W-1:0];
          tok_next.res.outcome              = tfc_pkg::OUT_ADDED;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      open          <= 1'b0;
      tok_out.valid <= 1'b0;
    end else if (advance) begin
      tok_out <= tok_next;
      if (do_alloc) begin
        open      <= 1'b1;
        key_src   <= tok_in.src;
        key_dst   <= tok_in.dst;
        key_sport <= tok_in.sport;
        key_dport <= tok_in.dport;
        count     <= CNT_W'(1);
      end else if (do_incr) begin
        count <= count + CNT_W'(1);
      end
    end
  end

endmodule
`default_nettype wire

// ===== hw/rtl/tcp_flow_table_classifier_top.sv =====
// Top level of the TCP flow table classifier: request entry, cell row, result register.
//
//   channel | valid     | stall     | payload
//   packet  | pkt_valid | pkt_stall | pkt (tfc_pkg::pkt_t)
//   result  | res_valid | res_stall | res (tfc_pkg::res_t)
//
// A request walks the row of TABLE_ENTRIES cells, one cell per cycle unless the
// row is frozen, through the entry register, the cell registers and then the
// result register. Only one packet is in flight: a new one is taken only once
// the last result enters the result register. A stalled result freezes the row
// once the next request reaches its end. Reset closes all connections.
`default_nettype none
module tcp_flow_table_classifier_top #(
  parameter int TABLE_ENTRIES    = tfc_pkg::TABLE_ENTRIES_DEF,
  parameter int PACKETS_PER_FLOW = tfc_pkg::PACKETS_PER_FLOW_DEF
) (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           pkt_valid,
  output logic                pkt_stall,
  input  wire tfc_pkg::pkt_t  pkt,
  output logic                res_valid,
  input  wire logic           res_stall,
  output tfc_pkg::res_t       res
);

  tfc_pkg::token_t tok [TABLE_ENTRIES+1];
  logic            inflight;
  logic            advance;
  logic            accept;
  logic            tail_valid;

  assign pkt_stall  = inflight || rst;
  assign accept     = pkt_valid && !pkt_stall;
  assign tail_valid = tok[TABLE_ENTRIES].valid;
  assign advance    = !(tail_valid && res_valid && res_stall);

  // entry register feeding the first cell
  always_ff @(posedge clk) begin
    if (rst) begin
      tok[0].valid <= 1'b0;
    end else if (accept) begin
      tok[0].valid                 <= 1'b1;
      tok[0].done                  <= 1'b0;
      tok[0].src                   <= pkt.src_address;
      tok[0].dst                   <= pkt.dst_address;
      tok[0].sport                 <= pkt.src_port_num;
      tok[0].dport                 <= pkt.dst_port_num;
      tok[0].res.flow_index        <= '0;
      tok[0].res.packet_slot       <= '0;
      tok[0].res.outcome           <= tfc_pkg::OUT_TABLE_FULL;
      tok[0].res.reverse_direction <= 1'b0;
      tok[0].res.batch_end         <= pkt.end_of_batch;
    end else if (advance) begin
      tok[0].valid <= 1'b0;
    end
  end

  for (genvar i = 0; i < TABLE_ENTRIES; i++) begin : g_cell
    tfc_cell #(
      .INDEX            (i),
      .PACKETS_PER_FLOW (PACKETS_PER_FLOW)
    ) u_cell (
      .clk     (clk),
      .rst     (rst),
      .advance (advance),
      .tok_in  (tok[i]),
      .tok_out (tok[i+1])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      inflight  <= 1'b0;
      res_valid <= 1'b0;
    end else begin
      if (accept) begin
        inflight <= 1'b1;
      end else if (tail_valid && advance) begin
        inflight <= 1'b0;
      end
      if (tail_valid && advance) begin
        res_valid <= 1'b1;
      end else if (!res_stall) begin
        res_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (tail_valid && advance) begin
      res <= tok[TABLE_ENTRIES].res;
    end
  end

endmodule
`default_nettype wire
